>>> rtl/core/lzss_pkg.sv
// ----------------------------------------------------------------------------
// lzss_pkg
// Shared types and constants for the LZSS stream decoder: beat payloads,
// register indexes and the command/status bundles between controller and
// datapath.
// ----------------------------------------------------------------------------
package lzss_pkg;

   // token format
   localparam int MIN_MATCH    = 3;
   localparam int WORD_BITS    = 16;
   localparam int GROUP_TOKENS = 8;

   // register file
   localparam int CSR_DATA_W = 6;
   localparam int LB_W       = 4;
   localparam int LM_W       = 6;
   localparam logic [LB_W-1:0] LB_RESET = 4'd4;
   localparam logic [LM_W-1:0] LM_RESET = 6'd15;
   localparam logic [LM_W-1:0] LM_MAX   = 6'd61;

   typedef enum logic [0:0] {
      CSR_LENGTH_BITS = 1'b0,
      CSR_LENGTH_MASK = 1'b1
   } csr_index_type;

   // input beat
   typedef struct packed {
      logic [7:0] in_byte;
      logic       in_last;
   } req_beat_type;

   // output beat
   typedef struct packed {
      logic [7:0] out_byte;
      logic       out_last;
   } rsp_beat_type;

   // controller to datapath
   typedef struct packed {
      logic accept;       // input beat taken this cycle
      logic capture_lit;  // hold the literal byte
      logic capture_low;  // hold the low byte of a match word
      logic start_copy;   // decode match word and launch the copy engine
      logic emit_lit;     // send the held literal and write it to history
      logic clear;        // end of stream: rewind history pointers
   } lzss_cmd_type;

   // datapath to controller
   typedef struct packed {
      logic out_free;     // output register can load this cycle
      logic word_zero;    // match word on the input is zero
      logic copy_done;    // last byte of the match leaves this cycle
   } lzss_stat_type;

endpackage

>>> rtl/core/lzss_ram.sv
// ----------------------------------------------------------------------------
// lzss_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module lzss_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, old data on a same-address write
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/core/lzss_dp.sv
// ----------------------------------------------------------------------------
// lzss_dp
// Datapath: registers, match word decode, history RAM with fill count,
// copy engine with read bypass, and the output register.
// ----------------------------------------------------------------------------
module lzss_dp import lzss_pkg::*; #(
   parameter int HISTORY_DEPTH = 4096,
   parameter int MAX_MATCH     = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  lzss_cmd_type          cmd,
   output lzss_stat_type         stat,
   input  logic [7:0]            req_byte,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_beat_type          rsp_data
);

   // usable history is the largest power of two not above the depth
   localparam int AW    = $clog2(HISTORY_DEPTH + 1) - 1;
   localparam int RDEP  = 1 << AW;
   localparam int LEN_W = $clog2(MAX_MATCH + 1);

   // registers
   logic [LB_W-1:0]  lb_ff, lb_in;
   logic [LM_W-1:0]  lm_ff, lm_in;
   logic [7:0]       lit_ff, lit_in;
   logic [7:0]       held_ff, held_in;
   logic [AW-1:0]    wp_ff, wp_in;
   logic [AW:0]      hw_ff, hw_in;
   logic [AW-1:0]    rd_addr_ff, rd_addr_in;
   logic [LEN_W-1:0] rd_left_ff, rd_left_in;
   logic [LEN_W-1:0] em_left_ff, em_left_in;
   logic             rd_pend_ff, rd_pend_in;
   logic             byp_hit_ff, byp_hit_in;
   logic [7:0]       byp_data_ff, byp_data_in;
   logic             hit_ok_ff, hit_ok_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_beat_type     rsp_data_ff, rsp_data_in;

   // combinational
   logic [4:0]           size_bits;
   logic [AW-1:0]        hmask;
   logic [WORD_BITS-1:0] word;
   logic [WORD_BITS-1:0] back_dist;
   logic [6:0]           len_raw;
   logic [LEN_W-1:0]     len_sat;
   logic [AW-1:0]        wpm;
   logic [AW-1:0]        src;
   logic [AW-1:0]        wa;
   logic                 out_free;
   logic                 emit_copy;
   logic                 emit;
   logic [7:0]           emit_byte;
   logic                 emit_last;
   logic                 issue;
   logic [7:0]           ram_q;
   logic [7:0]           copy_byte;

   // register file writes, length mask saturates
   assign csr_ready = 1'b1;

   always_comb begin
      lb_in = lb_ff;
      lm_in = lm_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_LENGTH_BITS: begin
               lb_in = csr_data[LB_W-1:0];
            end
            CSR_LENGTH_MASK: begin
               lm_in = (csr_data > LM_MAX) ? LM_MAX : csr_data;
            end
            default: begin
            end
         endcase
      end
   end

   // history window mask from the distance field width
   always_comb begin
      size_bits = 5'(WORD_BITS) - {1'b0, lb_ff};
      for (int i = 0; i < AW; i++) begin
         hmask[i] = (5'(i) < size_bits);
      end
   end

   // match word decode
   assign word      = {req_byte, held_ff};
   assign back_dist = word >> lb_ff;
   assign len_raw   = {1'b0, word[LM_W-1:0] & lm_ff} + 7'(MIN_MATCH);
   assign len_sat   = (len_raw > 7'(MAX_MATCH)) ? LEN_W'(MAX_MATCH) : LEN_W'(len_raw);
   assign wpm       = wp_ff & hmask;
   assign src       = (wpm - back_dist[AW-1:0]) & hmask;
   assign wa        = wpm;

   // emit arbitration: literal or copy byte into output register and history
   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign emit_copy = rd_pend_ff && out_free;
   assign emit      = cmd.emit_lit || emit_copy;
   assign copy_byte = byp_hit_ff ? byp_data_ff : (hit_ok_ff ? ram_q : 8'h00);
   assign emit_byte = cmd.emit_lit ? lit_ff : copy_byte;
   assign emit_last = cmd.emit_lit ? 1'b1 : (em_left_ff == LEN_W'(1));

   // a read goes out when the stage ahead is empty or draining
   assign issue = (rd_left_ff != '0) && (!rd_pend_ff || out_free);

   always_comb begin
      lit_in       = cmd.capture_lit ? req_byte : lit_ff;
      held_in      = cmd.capture_low ? req_byte : held_ff;
      wp_in        = wp_ff;
      hw_in        = hw_ff;
      rd_addr_in   = rd_addr_ff;
      rd_left_in   = rd_left_ff;
      em_left_in   = em_left_ff;
      rd_pend_in   = rd_pend_ff;
      byp_hit_in   = byp_hit_ff;
      byp_data_in  = byp_data_ff;
      hit_ok_in    = hit_ok_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;

      // output register drains
      if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end

      // history write and fill count
      if (emit) begin
         rsp_valid_in         = 1'b1;
         rsp_data_in.out_byte = emit_byte;
         rsp_data_in.out_last = emit_last;
         wp_in                = AW'(wa + 1'b1) & hmask;
         if ({1'b0, wa} == hw_ff) begin
            hw_in = hw_ff + 1'b1;
         end
      end

      // copy engine
      if (emit_copy) begin
         rd_pend_in = 1'b0;
         em_left_in = em_left_ff - 1'b1;
      end
      if (issue) begin
         rd_pend_in  = 1'b1;
         rd_left_in  = rd_left_ff - 1'b1;
         rd_addr_in  = AW'(rd_addr_ff + 1'b1) & hmask;
         byp_hit_in  = emit && (wa == rd_addr_ff);
         byp_data_in = emit_byte;
         hit_ok_in   = {1'b0, rd_addr_ff} < hw_ff;
      end
      if (cmd.start_copy) begin
         rd_left_in = len_sat;
         em_left_in = len_sat;
         rd_addr_in = src;
         wp_in      = wpm;
      end

      // stream end rewinds the history
      if (cmd.clear) begin
         wp_in   = '0;
         hw_in   = '0;
         held_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         lb_ff        <= LB_RESET;
         lm_ff        <= LM_RESET;
         wp_ff        <= '0;
         hw_ff        <= '0;
         held_ff      <= '0;
         rd_left_ff   <= '0;
         em_left_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         byp_hit_ff   <= 1'b0;
         hit_ok_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         lb_ff        <= lb_in;
         lm_ff        <= lm_in;
         wp_ff        <= wp_in;
         hw_ff        <= hw_in;
         held_ff      <= held_in;
         rd_left_ff   <= rd_left_in;
         em_left_ff   <= em_left_in;
         rd_pend_ff   <= rd_pend_in;
         byp_hit_ff   <= byp_hit_in;
         hit_ok_ff    <= hit_ok_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      lit_ff      <= lit_in;
      rd_addr_ff  <= rd_addr_in;
      byp_data_ff <= byp_data_in;
      rsp_data_ff <= rsp_data_in;
   end

   // history memory
   lzss_ram #(
      .WIDTH (8),
      .DEPTH (RDEP)
   ) u_hist (
      .clock   (clock),
      .wr_en   (emit),
      .wr_addr (wa),
      .wr_data (emit_byte),
      .rd_en   (issue),
      .rd_addr (rd_addr_ff),
      .rd_data (ram_q)
   );

   // status and outputs
   assign stat.out_free  = out_free;
   assign stat.word_zero = (word == '0);
   assign stat.copy_done = emit_copy && (em_left_ff == LEN_W'(1));
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_data       = rsp_data_ff;

   // checks
   a_lit_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(cmd.emit_lit && rd_pend_ff))
      else $error("literal emitted while a copy read is pending");

   a_wp_in_fill: assert property (@(posedge clock) disable iff (reset)
      {1'b0, wp_ff} <= hw_ff)
      else $error("write pointer beyond history fill count");

   a_copy_drained: assert property (@(posedge clock) disable iff (reset)
      stat.copy_done |=> (rd_left_ff == '0) && !rd_pend_ff)
      else $error("copy engine busy after final match byte");

endmodule

>>> rtl/core/lzss_ctrl.sv
// ----------------------------------------------------------------------------
// lzss_ctrl
// Controller: token sequencing over flag bytes, literals and match words,
// output sequencing and end-of-stream handling.
// ----------------------------------------------------------------------------
module lzss_ctrl import lzss_pkg::*; (
   input  logic          clock,
   input  logic          reset,
   input  logic          req_valid,
   output logic          req_ready,
   input  req_beat_type  req_data,
   output lzss_cmd_type  cmd,
   input  lzss_stat_type stat
);

   typedef enum logic [4:0] {
      ST_FLAG  = 5'b00001,
      ST_TOKEN = 5'b00010,
      ST_HIGH  = 5'b00100,
      ST_LIT   = 5'b01000,
      ST_COPY  = 5'b10000
   } state_type;

   state_type  state_ff, state_in;
   logic [7:0] flags_ff, flags_in;
   logic [3:0] tokens_ff, tokens_in;
   logic       last_ff, last_in;
   logic       accept;
   logic       do_clear;
   logic       tok_done;
   logic [3:0] tokens_dec;

   assign req_ready  = (state_ff == ST_FLAG) || (state_ff == ST_TOKEN) ||
                       (state_ff == ST_HIGH);
   assign accept     = req_valid && req_ready;
   assign tokens_dec = (tokens_ff != 4'd0) ? tokens_ff - 4'd1 : 4'd0;

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      flags_in   = flags_ff;
      tokens_in  = tokens_ff;
      last_in    = last_ff;
      cmd        = '0;
      cmd.accept = accept;
      do_clear   = 1'b0;
      tok_done   = 1'b0;

      case (state_ff)
         ST_FLAG: begin
            if (accept) begin
               flags_in  = req_data.in_byte;
               tokens_in = 4'(GROUP_TOKENS);
               state_in  = ST_TOKEN;
               do_clear  = req_data.in_last;
            end
         end
         ST_TOKEN: begin
            if (accept) begin
               if (flags_ff[0]) begin
                  cmd.capture_lit = 1'b1;
                  last_in         = req_data.in_last;
                  state_in        = ST_LIT;
               end else begin
                  cmd.capture_low = 1'b1;
                  state_in        = ST_HIGH;
                  do_clear        = req_data.in_last;
               end
            end
         end
         ST_HIGH: begin
            if (accept) begin
               if (stat.word_zero) begin
                  tokens_in = 4'd0;
                  state_in  = ST_FLAG;
                  do_clear  = req_data.in_last;
               end else begin
                  cmd.start_copy = 1'b1;
                  last_in        = req_data.in_last;
                  state_in       = ST_COPY;
               end
            end
         end
         ST_LIT: begin
            if (stat.out_free) begin
               cmd.emit_lit = 1'b1;
               tok_done     = 1'b1;
               do_clear     = last_ff;
            end
         end
         ST_COPY: begin
            if (stat.copy_done) begin
               tok_done = 1'b1;
               do_clear = last_ff;
            end
         end
         default: begin
            state_in = ST_FLAG;
         end
      endcase

      // token retired: shift flags, count down the group
      if (tok_done) begin
         flags_in  = {1'b0, flags_ff[7:1]};
         tokens_in = tokens_dec;
         state_in  = (tokens_dec == 4'd0) ? ST_FLAG : ST_TOKEN;
      end

      // end of stream returns everything to reset
      if (do_clear) begin
         cmd.clear = 1'b1;
         state_in  = ST_FLAG;
         flags_in  = 8'h00;
         tokens_in = 4'd0;
         last_in   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_FLAG;
         flags_ff  <= 8'h00;
         tokens_ff <= 4'd0;
         last_ff   <= 1'b0;
      end else begin
         state_ff  <= state_in;
         flags_ff  <= flags_in;
         tokens_ff <= tokens_in;
         last_ff   <= last_in;
      end
   end

   // checks
   a_done_in_copy: assert property (@(posedge clock) disable iff (reset)
      stat.copy_done |-> state_ff == ST_COPY)
      else $error("copy completion outside copy state");

   a_clear_rewinds: assert property (@(posedge clock) disable iff (reset)
      cmd.clear |=> (state_ff == ST_FLAG) && (tokens_ff == 4'd0))
      else $error("stream end did not return to flag byte");

endmodule

>>> rtl/core/lzss_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// lzss_stream_decoder_unit
// LZSS stream decoder, one compressed byte per input beat, one output byte
// per result beat.
// ----------------------------------------------------------------------------
// Works on one input beat at a time. A flag byte or a match low byte is only
// accepted, a literal accepted, then emitted, and a match high byte decoded;
// a history read goes ahead, then one output byte per cycle comes from the
// single history RAM read port, so the output side sets the sustained rate.
// Output stalls hold the copy in place. The history needs no clearing pass: a
// fill count marks which entries this stream has written, and unwritten
// entries read as zero. The user writes length_bits and length_mask via the
// csr port only while no beat is in flight; the block does not enforce it.
module lzss_stream_decoder_unit import lzss_pkg::*; #(
   parameter int HISTORY_DEPTH = 4096,
   parameter int MAX_MATCH     = 64
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  req_beat_type          req_data,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output rsp_beat_type          rsp_data,
   input  logic                  csr_valid,
   output logic                  csr_ready,
   input  csr_index_type         csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   lzss_cmd_type  cmd;
   lzss_stat_type stat;

   // token sequencer
   lzss_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .cmd       (cmd),
      .stat      (stat)
   );

   // history, copy engine and output register
   lzss_dp #(
      .HISTORY_DEPTH (HISTORY_DEPTH),
      .MAX_MATCH     (MAX_MATCH)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .stat      (stat),
      .req_byte  (req_data.in_byte),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

>>> bench/tb_lzss_stream_decoder_unit.sv
// ----------------------------------------------------------------------------
// tb_lzss_stream_decoder_unit
// Self-checking bench for the LZSS stream decoder. Compressed bytes are fed
// through a queue-driven driver. A byte-level model of the decoder predicts
// every output byte as each input beat is taken. Directed streams cover
// literals, overlapping and far matches, the zero word that ends a group, the
// dropped trailing match byte and the longest match. Random streams with
// random back-pressure then run under several register settings.
// ----------------------------------------------------------------------------
module tb_lzss_stream_decoder_unit import lzss_pkg::*; ();
   timeunit 1ns;
   timeprecision 1ps;

   localparam int HIST_DEPTH    = 4096;
   localparam int LONGEST_MATCH = 64;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES   = 500;
   localparam int LIMIT_CYCLES  = 4000000;
   localparam int ITEMS_PER_SET = 60;

   typedef enum logic [1:0] {
      EXPECT_FLAG  = 2'd0,
      EXPECT_TOKEN = 2'd1,
      EXPECT_HIGH  = 2'd2
   } decode_step_type;

   // clock and reset
   logic clock = 1'b0;
   logic reset = 1'b1;

   initial forever #5 clock = ~clock;

   // block ports
   logic                  req_valid = 1'b0;
   logic                  req_ready;
   req_beat_type          req_data  = '0;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   rsp_beat_type          rsp_data;
   logic                  csr_valid = 1'b0;
   logic                  csr_ready;
   csr_index_type         csr_index = CSR_LENGTH_BITS;
   logic [CSR_DATA_W-1:0] csr_data  = '0;

   lzss_stream_decoder_unit #(
      .HISTORY_DEPTH(HIST_DEPTH),
      .MAX_MATCH    (LONGEST_MATCH)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_data),
      .csr_valid(csr_valid),
      .csr_ready(csr_ready),
      .csr_index(csr_index),
      .csr_data (csr_data)
   );

   // stimulus and scoreboard storage
   req_beat_type pending_beats [$];
   rsp_beat_type expected_bytes [$];
   logic [7:0]   burst_bytes [$];
   rsp_beat_type want_beat;

   int unsigned beats_taken     = 0;
   int unsigned results_checked = 0;
   int unsigned check_errors    = 0;
   int unsigned settings_used   = 0;
   int unsigned cycle_count     = 0;
   logic [3:0]  cur_lb;

   // decoder model state
   logic [7:0]      hist_mem [HIST_DEPTH];
   int unsigned     wr_ptr;
   int unsigned     tokens_left;
   logic [7:0]      flag_reg;
   logic [7:0]      held_low;
   decode_step_type dec_step;
   logic [3:0]      cfg_lb;
   logic [5:0]      cfg_lm;

   // random idle length: mostly none, some short, a few long
   function automatic int idle_len(input bit steady);
      int r;
      r = $urandom_range(0, 99);
      if (steady || r < 60) return 0;
      if (r < 92) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // history window for a split point, capped at the physical depth
   function automatic int unsigned window_size(input logic [3:0] lb);
      int unsigned sz;
      sz = 32'd1 << (WORD_BITS - lb);
      while (sz > HIST_DEPTH) sz = sz >> 1;
      return sz;
   endfunction

   function automatic void clear_stream();
      foreach (hist_mem[i]) hist_mem[i] = 8'h00;
      wr_ptr      = 0;
      tokens_left = 0;
      flag_reg    = 8'h00;
      held_low    = 8'h00;
      dec_step    = EXPECT_FLAG;
   endfunction

   // output byte also lands in the history
   function automatic void emit_byte(input logic [7:0] b, input int unsigned hmask);
      wr_ptr = wr_ptr & hmask;
      hist_mem[wr_ptr] = b;
      wr_ptr = (wr_ptr + 1) & hmask;
      burst_bytes.push_back(b);
   endfunction

   function automatic void close_token();
      flag_reg = flag_reg >> 1;
      if (tokens_left > 0) tokens_left--;
      dec_step = (tokens_left == 0) ? EXPECT_FLAG : EXPECT_TOKEN;
   endfunction

   // work out the output bytes caused by one compressed byte
   function automatic void decode_beat(input req_beat_type beat);
      int unsigned  hmask;
      int unsigned  word;
      int unsigned  run_len;
      int unsigned  back_dist;
      int unsigned  src;
      rsp_beat_type exp_beat;
      hmask = window_size(cfg_lb) - 1;
      burst_bytes.delete();
      case (dec_step)
         EXPECT_TOKEN: begin
            if (flag_reg[0]) begin
               emit_byte(beat.in_byte, hmask);
               close_token();
            end else begin
               held_low = beat.in_byte;
               dec_step = EXPECT_HIGH;
            end
         end
         EXPECT_HIGH: begin
            word = 32'({beat.in_byte, held_low});
            if (word == 0) begin
               // zero word ends the group
               tokens_left = 0;
               dec_step    = EXPECT_FLAG;
            end else begin
               run_len = (word & cfg_lm) + MIN_MATCH;
               if (run_len > LONGEST_MATCH) run_len = LONGEST_MATCH;
               back_dist = word >> cfg_lb;
               wr_ptr    = wr_ptr & hmask;
               src       = (wr_ptr - back_dist) & hmask;
               for (int j = 0; j < run_len; j++)
                  emit_byte(hist_mem[(src + j) & hmask], hmask);
               close_token();
            end
         end
         default: begin
            flag_reg    = beat.in_byte;
            tokens_left = GROUP_TOKENS;
            dec_step    = EXPECT_TOKEN;
         end
      endcase
      foreach (burst_bytes[i]) begin
         exp_beat.out_byte = burst_bytes[i];
         exp_beat.out_last = (i == burst_bytes.size() - 1);
         expected_bytes.push_back(exp_beat);
      end
      if (beat.in_last) clear_stream();
   endfunction

   // model update on every taken input beat and register write
   always @(posedge clock) begin
      if (reset) begin
         cfg_lb = LB_RESET;
         cfg_lm = LM_RESET;
         clear_stream();
      end else begin
         if (csr_valid && csr_ready) begin
            if (csr_index == CSR_LENGTH_BITS) cfg_lb = csr_data[LB_W-1:0];
            else cfg_lm = (csr_data > LM_MAX) ? LM_MAX : csr_data[LM_W-1:0];
         end
         if (req_valid && req_ready) begin
            decode_beat(req_data);
            beats_taken++;
         end
      end
   end

   // input driver, fed from the pending queue
   int req_gap    = 0;
   bit req_steady = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
         req_gap   <= 0;
      end else if (!req_valid || req_ready) begin
         if (req_gap > 0) begin
            req_valid <= 1'b0;
            req_gap   <= req_gap - 1;
         end else if (pending_beats.size() > 0) begin
            req_valid <= 1'b1;
            req_data  <= pending_beats.pop_front();
            req_gap   <= idle_len(req_steady);
            if ($urandom_range(0, 63) == 0) req_steady <= !req_steady;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // output ready with random stalls and one long hold-off
   int rsp_gap    = 0;
   int hold_left  = 0;
   bit hold_armed = 1'b1;
   bit rsp_steady = 1'b0;

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= 0;
      end else if (hold_left > 0) begin
         rsp_ready <= 1'b0;
         hold_left <= hold_left - 1;
      end else if (hold_armed && results_checked >= 150) begin
         hold_armed <= 1'b0;
         hold_left  <= HOLD_CYCLES;
         rsp_ready  <= 1'b0;
      end else if (rsp_gap > 0) begin
         rsp_ready <= 1'b0;
         rsp_gap   <= rsp_gap - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 3) == 0) rsp_gap <= idle_len(rsp_steady);
         if ($urandom_range(0, 63) == 0) rsp_steady <= !rsp_steady;
      end
   end

   // output beat check against the oldest expected byte
   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         results_checked++;
         if (expected_bytes.size() == 0) begin
            check_errors++;
            $error("output beat with nothing expected: out_byte %02h out_last %0b",
                   rsp_data.out_byte, rsp_data.out_last);
         end else begin
            want_beat = expected_bytes.pop_front();
            if (rsp_data.out_byte !== want_beat.out_byte) begin
               check_errors++;
               $error("out_byte: expected %02h actual %02h",
                      want_beat.out_byte, rsp_data.out_byte);
            end
            if (rsp_data.out_last !== want_beat.out_last) begin
               check_errors++;
               $error("out_last: expected %0b actual %0b",
                      want_beat.out_last, rsp_data.out_last);
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > LIMIT_CYCLES) begin
         $display("timeout after %0d cycles, %0d bytes still expected",
                  cycle_count, expected_bytes.size());
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic push_beat(input logic [7:0] b, input bit last);
      req_beat_type beat;
      beat.in_byte = b;
      beat.in_last = last;
      pending_beats.push_back(beat);
   endtask

   task automatic push_word(input logic [15:0] word, input bit last);
      push_beat(word[7:0], 1'b0);
      push_beat(word[15:8], last);
   endtask

   // all beats taken, all bytes seen, then let the block settle
   task automatic wait_idle();
      while (pending_beats.size() != 0 || req_valid || expected_bytes.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input csr_index_type idx, input logic [CSR_DATA_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
   endtask

   task automatic set_regs(input logic [3:0] lb, input logic [5:0] lm);
      wait_idle();
      write_reg(CSR_LENGTH_BITS, {2'b00, lb});
      write_reg(CSR_LENGTH_MASK, lm);
      cur_lb = lb;
      settings_used++;
   endtask

   // random streams: mostly well-formed groups, some cut short, some noise
   task automatic random_streams(input int n_items);
      int          queued;
      logic [7:0]  flags;
      int          cut;
      bit          end_stream;
      int unsigned back_dist;
      logic [15:0] word;
      queued = 0;
      while (queued < n_items) begin
         if ($urandom_range(0, 9) == 0) begin
            // noise bytes, closed by end of stream to resync
            repeat ($urandom_range(0, 2)) begin
               push_beat(8'($urandom_range(0, 255)), 1'b0);
               queued++;
            end
            push_beat(8'($urandom_range(0, 255)), 1'b1);
            queued++;
         end else begin
            flags      = 8'($urandom_range(0, 255));
            cut        = ($urandom_range(0, 11) == 0) ? $urandom_range(0, 7) : GROUP_TOKENS;
            end_stream = ($urandom_range(0, 5) == 0);
            push_beat(flags, 1'b0);
            queued++;
            for (int t = 0; t < GROUP_TOKENS; t++) begin
               if (t == cut) begin
                  // stream ends inside the group
                  push_beat(8'($urandom_range(0, 255)), 1'b1);
                  queued++;
                  break;
               end
               if (flags[t]) begin
                  push_beat(8'($urandom_range(0, 255)),
                            end_stream && t == GROUP_TOKENS - 1);
                  queued++;
               end else if ($urandom_range(0, 15) == 0) begin
                  push_word(16'h0000, end_stream);
                  queued += 2;
                  break;
               end else begin
                  back_dist = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 40)
                                                         : $urandom_range(0, 65535);
                  word = 16'((back_dist << cur_lb) | $urandom_range(0, 63));
                  if (word == 16'h0000) word = 16'h0001;
                  push_word(word, end_stream && t == GROUP_TOKENS - 1);
                  queued += 2;
               end
            end
         end
      end
   endtask

   // stimulus sequence
   initial begin
      cur_lb = LB_RESET;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      // reset settings: literals at both byte extremes, overlapping copy,
      // far copy, zero word, end of stream and a lone trailing match byte
      push_beat(8'h05, 1'b0);
      push_beat(8'h00, 1'b0);
      push_word(16'h001F, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_word(16'hFFFF, 1'b0);
      push_word(16'h0000, 1'b0);
      push_beat(8'hFF, 1'b0);
      push_beat(8'hAB, 1'b0);
      push_beat(8'h55, 1'b1);
      push_beat(8'h00, 1'b0);
      push_beat(8'h12, 1'b1);
      settings_used++;

      // widest split and a clamped mask: two-byte window, longest match
      set_regs(4'd15, 6'd63);
      push_beat(8'h00, 1'b0);
      push_word(16'hFFFF, 1'b1);
      random_streams(ITEMS_PER_SET);

      set_regs(4'd4, 6'd0);
      random_streams(ITEMS_PER_SET);
      // split below the window limit
      set_regs(4'd0, 6'd61);
      random_streams(ITEMS_PER_SET);
      set_regs(4'd8, 6'd7);
      random_streams(ITEMS_PER_SET);
      set_regs(4'd12, 6'd30);
      random_streams(ITEMS_PER_SET);
      repeat (2) begin
         set_regs(4'($urandom_range(0, 15)), 6'($urandom_range(0, 63)));
         random_streams(ITEMS_PER_SET);
      end
      set_regs(LB_RESET, LM_RESET);
      random_streams(ITEMS_PER_SET);

      wait_idle();
      $display("decoded %0d compressed bytes into %0d output bytes", beats_taken,
               results_checked);
      $display("covered %0d register settings, one long output hold-off", settings_used);
      if (check_errors == 0 && expected_bytes.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

>>> files.f
rtl/core/lzss_pkg.sv
rtl/core/lzss_ram.sv
rtl/core/lzss_dp.sv
rtl/core/lzss_ctrl.sv
rtl/core/lzss_stream_decoder_unit.sv
bench/tb_lzss_stream_decoder_unit.sv
